FILE: rtl/core/kwl_pkg.sv
// ============================================================================
// kwl_pkg
// Shared types and constants of the K-weighted loudness window engine.
// ============================================================================
package kwl_pkg;

    // Fixed field widths
    localparam int CHANNEL_BITS   = 3;
    localparam int STEP_LEN_BITS  = 16;
    localparam int COEF_BITS      = 32;
    localparam int SIG_BITS       = 32;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_IDX_BITS   = 3;
    localparam int ENERGY_BITS    = 34;
    localparam int ENERGY_SHIFT   = 30;
    localparam int STEP_BITS      = 56;
    localparam int SUM_BITS       = 60;
    localparam int MOM_CNT_BITS   = 3;
    localparam int ST_CNT_BITS    = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HP_GAIN        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HP_FEEDBACK    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHELF_B0       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHELF_B1       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHELF_B2       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHELF_FEEDBACK = 3'd6;

    // Register reset values
    localparam logic [STEP_LEN_BITS-1:0] RST_STEP_LENGTH = 16'd4800;
    localparam logic signed [COEF_BITS-1:0] RST_HP_GAIN  = 32'sd533965824;
    localparam logic signed [COEF_BITS-1:0] RST_SHELF_B0 = 32'sd823165568;
    localparam logic signed [COEF_BITS-1:0] RST_SHELF_B1 = -32'sd1486264320;
    localparam logic signed [COEF_BITS-1:0] RST_SHELF_B2 = 32'sd684093440;

    // Top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILTER,
        ST_FRAME,
        ST_WINDOW,
        ST_OUTPUT
    } t_top_state;

    // Filter unit control and status
    typedef struct packed {
        logic                    go;
        logic [CHANNEL_BITS-1:0] channel;
    } t_filt_req;

    typedef struct packed {
        logic                   done;
        logic [ENERGY_BITS-1:0] energy;
    } t_filt_rsp;

    // Window unit control and status
    typedef struct packed {
        logic                 close;
        logic [STEP_BITS-1:0] energy;
    } t_win_req;

    typedef struct packed {
        logic                    done;
        logic [SUM_BITS-1:0]     mom_sum;
        logic [MOM_CNT_BITS-1:0] mom_steps;
        logic [SUM_BITS-1:0]     st_sum;
        logic [ST_CNT_BITS-1:0]  st_steps;
        logic                    block_ready;
    } t_win_rsp;

endpackage

FILE: rtl/core/kwl_stream_if.sv
// ============================================================================
// kwl_in_if / kwl_out_if
// Valid/ready channels for audio samples in and window results out.
// ============================================================================
interface kwl_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   sample;
    logic [kwl_pkg::CHANNEL_BITS-1:0] channel;
    logic                            frame_end;

    modport source (output valid, sample, channel, frame_end, input ready);
    modport sink   (input valid, sample, channel, frame_end, output ready);
endinterface

interface kwl_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                             valid;
    logic                             ready;
    logic [kwl_pkg::SUM_BITS-1:0]     momentary_sum;
    logic [kwl_pkg::MOM_CNT_BITS-1:0] momentary_steps;
    logic [kwl_pkg::SUM_BITS-1:0]     short_term_sum;
    logic [kwl_pkg::ST_CNT_BITS-1:0]  short_term_steps;
    logic                             block_ready;
    logic [SAMPLE_BITS-1:0]           peak_magnitude;

    modport source (output valid, momentary_sum, momentary_steps, short_term_sum,
                    short_term_steps, block_ready, peak_magnitude, input ready);
    modport sink   (input valid, momentary_sum, momentary_steps, short_term_sum,
                    short_term_steps, block_ready, peak_magnitude, output ready);
endinterface

FILE: rtl/core/kwl_ram.sv
// ============================================================================
// kwl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/kwl_filter.sv
// ============================================================================
// kwl_filter
// Per-channel K-weighting biquad pair on one shared 32x32 multiplier.
// Filter history lives in a RAM, read at start and written back at the end.
// ============================================================================
module kwl_filter #(
    parameter int MAX_CHANNELS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 29
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kwl_pkg::t_filt_req                 i_req,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic signed [kwl_pkg::COEF_BITS-1:0] i_hp_gain,
    input  logic [kwl_pkg::CFG_DATA_BITS-1:0]  i_hp_feedback,
    input  logic signed [kwl_pkg::COEF_BITS-1:0] i_shelf_b0,
    input  logic signed [kwl_pkg::COEF_BITS-1:0] i_shelf_b1,
    input  logic signed [kwl_pkg::COEF_BITS-1:0] i_shelf_b2,
    input  logic [kwl_pkg::CFG_DATA_BITS-1:0]  i_shelf_feedback,
    output kwl_pkg::t_filt_rsp                 o_rsp
);
    import kwl_pkg::*;

    localparam int CAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SSH = (SIG_BITS - 2) - (SAMPLE_BITS - 1); // scale to Q2.30
    localparam int LSH = (SSH >= 0) ? SSH : 0;
    localparam int RSH = (SSH < 0) ? -SSH : 0;
    localparam int AW  = 68 - COEF_FRAC_BITS;               // accumulator width
    localparam int PW  = 2 * SIG_BITS;

    // Product schedule
    localparam logic [3:0] K_HP_X0  = 4'd0;
    localparam logic [3:0] K_HP_X2  = 4'd1;
    localparam logic [3:0] K_HP_X1  = 4'd2;
    localparam logic [3:0] K_HP_Y1  = 4'd3;
    localparam logic [3:0] K_HP_Y2  = 4'd4;
    localparam logic [3:0] K_SH_X1  = 4'd5;
    localparam logic [3:0] K_SH_X2  = 4'd6;
    localparam logic [3:0] K_SH_Y1  = 4'd7;
    localparam logic [3:0] K_SH_Y2  = 4'd8;
    localparam logic [3:0] K_SH_X0  = 4'd9;
    localparam logic [3:0] K_ENERGY = 4'd11;
    localparam logic [3:0] K_LAST   = 4'd12;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] hx1;
        logic signed [SAMPLE_BITS-1:0] hx2;
        logic signed [SIG_BITS-1:0]    hy1;
        logic signed [SIG_BITS-1:0]    hy2;
        logic signed [SIG_BITS-1:0]    sx1;
        logic signed [SIG_BITS-1:0]    sx2;
        logic signed [SIG_BITS-1:0]    sy1;
        logic signed [SIG_BITS-1:0]    sy2;
    } t_fstate;

    localparam int FSW = $bits(t_fstate);

    function automatic logic signed [SIG_BITS-1:0] to_sig(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        logic signed [PW-1:0] w;
        w = PW'(v);
        w = (w <<< LSH) >>> RSH;
        return w[SIG_BITS-1:0];
    endfunction

    function automatic logic signed [SIG_BITS-1:0] sat32(input logic signed [AW-1:0] v);
        logic fits;
        fits = (&v[AW-1:SIG_BITS-1]) || !(|v[AW-1:SIG_BITS-1]);
        if (fits) begin
            return v[SIG_BITS-1:0];
        end
        return v[AW-1] ? {1'b1, {(SIG_BITS-1){1'b0}}} : {1'b0, {(SIG_BITS-1){1'b1}}};
    endfunction

    logic [CAW-1:0]                 r_addr;
    logic signed [SAMPLE_BITS-1:0]  r_x;
    logic [MAX_CHANNELS-1:0]        r_valid;
    logic                           r_ld;
    logic                           r_busy;
    logic [3:0]                     r_k;
    logic                           r_pv;
    logic [3:0]                     r_pk;
    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_acc_hp;
    logic signed [AW-1:0]           r_acc_sh;
    t_fstate                        r_st;
    t_fstate                        wb_st;
    logic [FSW-1:0]                 ram_rdata;
    logic [CAW-1:0]                 req_addr;
    logic signed [SIG_BITS-1:0]     op_a;
    logic signed [SIG_BITS-1:0]     op_b;
    logic signed [SIG_BITS-1:0]     h;
    logic signed [SIG_BITS-1:0]     y;
    logic                           issue;
    logic signed [PW-1:0]           t_plain;
    logic signed [PW-1:0]           t_neg2;
    logic                           wb;

    assign req_addr = CAW'({1'b0, i_req.channel});
    assign h        = sat32(r_acc_hp);
    assign y        = sat32(r_acc_sh);
    assign issue    = r_busy && ((r_k <= K_SH_X0) || (r_k == K_ENERGY));
    assign wb       = r_busy && (r_k == K_LAST);

    // Filter history memory
    kwl_ram #(.WIDTH(FSW), .DEPTH(MAX_CHANNELS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wb),
        .i_waddr (r_addr),
        .i_wdata (wb_st),
        .i_re    (i_req.go),
        .i_raddr (req_addr),
        .o_rdata (ram_rdata)
    );

    // Multiplier operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_k)
            K_HP_X0:  begin op_a = i_hp_gain; op_b = to_sig(r_x); end
            K_HP_X2:  begin op_a = i_hp_gain; op_b = to_sig(r_st.hx2); end
            K_HP_X1:  begin op_a = i_hp_gain; op_b = to_sig(r_st.hx1); end
            K_HP_Y1:  begin op_a = i_hp_feedback[63:32]; op_b = r_st.hy1; end
            K_HP_Y2:  begin op_a = i_hp_feedback[31:0];  op_b = r_st.hy2; end
            K_SH_X1:  begin op_a = i_shelf_b1; op_b = r_st.sx1; end
            K_SH_X2:  begin op_a = i_shelf_b2; op_b = r_st.sx2; end
            K_SH_Y1:  begin op_a = i_shelf_feedback[63:32]; op_b = r_st.sy1; end
            K_SH_Y2:  begin op_a = i_shelf_feedback[31:0];  op_b = r_st.sy2; end
            K_SH_X0:  begin op_a = i_shelf_b0; op_b = h; end
            K_ENERGY: begin op_a = y; op_b = y; end
            default:  begin op_a = '0; op_b = '0; end
        endcase
    end

    // Floored terms; the high-pass b1 tap is -2*b0, applied before the floor
    assign t_plain = r_prod >>> COEF_FRAC_BITS;
    assign t_neg2  = (-(r_prod <<< 1)) >>> COEF_FRAC_BITS;

    // Updated history for write-back
    always_comb begin
        wb_st     = r_st;
        wb_st.hx1 = r_x;
        wb_st.hx2 = r_st.hx1;
        wb_st.hy1 = h;
        wb_st.hy2 = r_st.hy1;
        wb_st.sx1 = h;
        wb_st.sx2 = r_st.sx1;
        wb_st.sy1 = y;
        wb_st.sy2 = r_st.sy1;
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld    <= 1'b0;
            r_busy  <= 1'b0;
            r_k     <= '0;
            r_pv    <= 1'b0;
            r_valid <= '0;
        end else begin
            r_ld <= i_req.go;
            r_pv <= issue;
            if (r_ld) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 4'd1;
                if (r_k == K_LAST) begin
                    r_busy <= 1'b0;
                end
            end
            if (wb) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    // Datapath: latch, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_addr <= req_addr;
            r_x    <= i_sample;
        end
        if (r_ld) begin
            r_st     <= r_valid[r_addr] ? t_fstate'(ram_rdata) : '0;
            r_acc_hp <= '0;
            r_acc_sh <= '0;
        end
        if (issue) begin
            r_prod <= op_a * op_b;
        end
        r_pk <= r_k;
        if (r_pv) begin
            unique case (r_pk)
                K_HP_X0, K_HP_X2: r_acc_hp <= r_acc_hp + t_plain[AW-1:0];
                K_HP_X1:          r_acc_hp <= r_acc_hp + t_neg2[AW-1:0];
                K_HP_Y1, K_HP_Y2: r_acc_hp <= r_acc_hp - t_plain[AW-1:0];
                K_SH_X1, K_SH_X2, K_SH_X0: r_acc_sh <= r_acc_sh + t_plain[AW-1:0];
                K_SH_Y1, K_SH_Y2: r_acc_sh <= r_acc_sh - t_plain[AW-1:0];
                default: ;
            endcase
        end
    end

    assign o_rsp.done   = wb;
    assign o_rsp.energy = r_prod[ENERGY_SHIFT+ENERGY_BITS-1:ENERGY_SHIFT];
endmodule

FILE: rtl/core/kwl_window.sv
// ============================================================================
// kwl_window
// Step history RAM and windowed energy sums, one history entry per cycle.
// ============================================================================
module kwl_window #(
    parameter int HISTORY_DEPTH    = 40,
    parameter int MOMENTARY_STEPS  = 4,
    parameter int SHORT_TERM_STEPS = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kwl_pkg::t_win_req i_req,
    output kwl_pkg::t_win_rsp o_rsp
);
    import kwl_pkg::*;

    localparam int HAW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CMAX = (HISTORY_DEPTH > SHORT_TERM_STEPS) ? HISTORY_DEPTH
                                                             : SHORT_TERM_STEPS;
    localparam int CW   = $clog2(CMAX + 1);

    logic [HAW-1:0]       r_wpos;
    logic [HAW-1:0]       r_rp;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_mn;
    logic [CW-1:0]        r_sn;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_rk;
    logic                 r_rv;
    logic                 r_busy;
    logic                 r_done;
    logic [SUM_BITS-1:0]  r_acc_m;
    logic [SUM_BITS-1:0]  r_acc_s;
    logic [STEP_BITS-1:0] rdata;
    logic [CW-1:0]        fill_nx;
    logic [CW-1:0]        mn_nx;
    logic [CW-1:0]        sn_nx;
    logic                 issue;
    logic                 last;
    logic [SUM_BITS:0]    sum_m;
    logic [SUM_BITS:0]    sum_s;

    kwl_ram #(.WIDTH(STEP_BITS), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.close),
        .i_waddr (r_wpos),
        .i_wdata (i_req.energy),
        .i_re    (issue),
        .i_raddr (r_rp),
        .o_rdata (rdata)
    );

    // Counts for the window that the new step completes
    always_comb begin
        fill_nx = (r_fill < CW'(HISTORY_DEPTH)) ? CW'(r_fill + 1'b1) : r_fill;
        mn_nx   = (fill_nx < CW'(MOMENTARY_STEPS))  ? fill_nx : CW'(MOMENTARY_STEPS);
        sn_nx   = (fill_nx < CW'(SHORT_TERM_STEPS)) ? fill_nx : CW'(SHORT_TERM_STEPS);
    end

    assign issue = r_busy && (r_k < r_cnt);
    assign last  = r_rv && (r_rk == CW'(r_cnt - 1'b1));
    assign sum_m = {1'b0, r_acc_m} + (SUM_BITS+1)'(rdata);
    assign sum_s = {1'b0, r_acc_s} + (SUM_BITS+1)'(rdata);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
            r_busy <= 1'b0;
            r_rv   <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_rv   <= issue;
            r_done <= last;
            if (i_req.close) begin
                r_wpos <= (r_wpos == HAW'(HISTORY_DEPTH - 1)) ? '0 : HAW'(r_wpos + 1'b1);
                r_fill <= fill_nx;
                r_busy <= 1'b1;
                r_k    <= '0;
            end else begin
                if (issue) begin
                    r_k <= CW'(r_k + 1'b1);
                end
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Read pointer walks from the newest entry backward; saturating sums
    always_ff @(posedge i_clk) begin
        r_rk <= r_k;
        if (i_req.close) begin
            r_rp    <= r_wpos;
            r_mn    <= mn_nx;
            r_sn    <= sn_nx;
            r_cnt   <= (mn_nx > sn_nx) ? mn_nx : sn_nx;
            r_acc_m <= '0;
            r_acc_s <= '0;
        end else begin
            if (issue) begin
                r_rp <= (r_rp == '0) ? HAW'(HISTORY_DEPTH - 1) : HAW'(r_rp - 1'b1);
            end
            if (r_rv && (r_rk < r_mn)) begin
                r_acc_m <= sum_m[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_m[SUM_BITS-1:0];
            end
            if (r_rv && (r_rk < r_sn)) begin
                r_acc_s <= sum_s[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_s[SUM_BITS-1:0];
            end
        end
    end

    assign o_rsp.done        = r_done;
    assign o_rsp.mom_sum     = r_acc_m;
    assign o_rsp.mom_steps   = r_mn[MOM_CNT_BITS-1:0];
    assign o_rsp.st_sum      = r_acc_s;
    assign o_rsp.st_steps    = r_sn[ST_CNT_BITS-1:0];
    assign o_rsp.block_ready = (r_fill >= CW'(MOMENTARY_STEPS));
endmodule

FILE: rtl/core/k_weighted_loudness_windows_core.sv
// ============================================================================
// k_weighted_loudness_windows_core
// K-weighted energy per step with momentary and short-term window sums.
// ============================================================================
//  channel   | dir | handshake            | payload
//  i_in      | in  | valid/ready          | sample, channel, frame_end
//  o_out     | out | valid/ready          | window sums, step counts, flag, peak
//  i_cfg_*   | in  | write enable only    | register index, 64-bit data
//
//  An in-range sample is filtered before the next ready: the
//  single 32x32 multiplier runs eleven products around a state RAM
//  read and write-back. An out-of-range channel skips the filter.
//  A frame end that closes a step adds the window pass, one history entry per
//  cycle (up to the larger window, 30 by default). A stalled result is held
//  in the output register; the next items are taken until another step
//  closes. Reset is synchronous; no clearing pass is run.
// ============================================================================
module k_weighted_loudness_windows_core #(
    parameter int MAX_CHANNELS     = 8,
    parameter int HISTORY_DEPTH    = 40,
    parameter int MOMENTARY_STEPS  = 4,
    parameter int SHORT_TERM_STEPS = 30,
    parameter int SAMPLE_BITS      = 24,
    parameter int COEF_FRAC_BITS   = 29
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    kwl_in_if.sink                               i_in,
    kwl_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [kwl_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [kwl_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import kwl_pkg::*;

    t_top_state                   r_state, n_state;
    logic [STEP_LEN_BITS-1:0]     r_step_length;
    logic signed [COEF_BITS-1:0]  r_hp_gain;
    logic [CFG_DATA_BITS-1:0]     r_hp_feedback;
    logic signed [COEF_BITS-1:0]  r_shelf_b0;
    logic signed [COEF_BITS-1:0]  r_shelf_b1;
    logic signed [COEF_BITS-1:0]  r_shelf_b2;
    logic [CFG_DATA_BITS-1:0]     r_shelf_feedback;
    logic                         r_fend;
    logic [STEP_BITS-1:0]         r_energy;
    logic [STEP_LEN_BITS-1:0]     r_frames;
    logic [SAMPLE_BITS-1:0]       r_peak;
    logic                         r_ovalid;
    t_win_rsp                     r_res;
    logic [SAMPLE_BITS-1:0]       r_res_peak;

    t_filt_req                    filt_req;
    t_filt_rsp                    filt_rsp;
    t_win_req                     win_req;
    t_win_rsp                     win_rsp;
    logic                         accept;
    logic                         in_range;
    logic [SAMPLE_BITS-1:0]       mag;
    logic [STEP_LEN_BITS-1:0]     frames_nx;
    logic [STEP_LEN_BITS-1:0]     len;
    logic                         closing;
    logic                         load_out;
    logic [STEP_BITS:0]           energy_sum;

    assign accept    = i_in.valid && i_in.ready;
    assign in_range  = (32'(i_in.channel) < MAX_CHANNELS);
    assign mag       = i_in.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.sample)
                                                  : SAMPLE_BITS'(i_in.sample);
    assign frames_nx = r_frames + 1'b1;
    assign len       = (r_step_length == '0) ? STEP_LEN_BITS'(1) : r_step_length;
    assign closing   = r_fend && (frames_nx >= len);
    assign energy_sum = {1'b0, r_energy} + (STEP_BITS+1)'(filt_rsp.energy);

    // Sequencer: next state and strobes
    always_comb begin
        n_state          = r_state;
        i_in.ready       = 1'b0;
        filt_req.go      = 1'b0;
        filt_req.channel = i_in.channel;
        win_req.close    = 1'b0;
        win_req.energy   = r_energy;
        load_out         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    filt_req.go = in_range;
                    n_state     = in_range ? ST_FILTER : ST_FRAME;
                end
            end
            ST_FILTER: begin
                if (filt_rsp.done) begin
                    n_state = ST_FRAME;
                end
            end
            ST_FRAME: begin
                win_req.close = closing;
                n_state       = closing ? ST_WINDOW : ST_IDLE;
            end
            ST_WINDOW: begin
                if (win_rsp.done) begin
                    n_state = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!r_ovalid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_length    <= RST_STEP_LENGTH;
            r_hp_gain        <= RST_HP_GAIN;
            r_hp_feedback    <= '0;
            r_shelf_b0       <= RST_SHELF_B0;
            r_shelf_b1       <= RST_SHELF_B1;
            r_shelf_b2       <= RST_SHELF_B2;
            r_shelf_feedback <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_LENGTH:    r_step_length    <= i_cfg_wdata[STEP_LEN_BITS-1:0];
                CFG_HP_GAIN:        r_hp_gain        <= i_cfg_wdata[COEF_BITS-1:0];
                CFG_HP_FEEDBACK:    r_hp_feedback    <= i_cfg_wdata;
                CFG_SHELF_B0:       r_shelf_b0       <= i_cfg_wdata[COEF_BITS-1:0];
                CFG_SHELF_B1:       r_shelf_b1       <= i_cfg_wdata[COEF_BITS-1:0];
                CFG_SHELF_B2:       r_shelf_b2       <= i_cfg_wdata[COEF_BITS-1:0];
                CFG_SHELF_FEEDBACK: r_shelf_feedback <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Step energy, frame count, peak and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
            r_frames <= '0;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (filt_rsp.done) begin
                r_energy <= energy_sum[STEP_BITS] ? {STEP_BITS{1'b1}}
                                                  : energy_sum[STEP_BITS-1:0];
            end
            if ((r_state == ST_FRAME) && r_fend) begin
                r_frames <= closing ? '0 : frames_nx;
                if (closing) begin
                    r_energy <= '0;
                end
            end
            if (accept && in_range && (mag > r_peak)) begin
                r_peak <= mag;
            end
            if (load_out) begin
                r_peak <= '0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fend <= i_in.frame_end;
        end
        if (load_out) begin
            r_res      <= win_rsp;
            r_res_peak <= r_peak;
        end
    end

    kwl_filter #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_filter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (filt_req),
        .i_sample         (i_in.sample),
        .i_hp_gain        (r_hp_gain),
        .i_hp_feedback    (r_hp_feedback),
        .i_shelf_b0       (r_shelf_b0),
        .i_shelf_b1       (r_shelf_b1),
        .i_shelf_b2       (r_shelf_b2),
        .i_shelf_feedback (r_shelf_feedback),
        .o_rsp            (filt_rsp)
    );

    kwl_window #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .MOMENTARY_STEPS  (MOMENTARY_STEPS),
        .SHORT_TERM_STEPS (SHORT_TERM_STEPS)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (win_req),
        .o_rsp   (win_rsp)
    );

    assign o_out.valid            = r_ovalid;
    assign o_out.momentary_sum    = r_res.mom_sum;
    assign o_out.momentary_steps  = r_res.mom_steps;
    assign o_out.short_term_sum   = r_res.st_sum;
    assign o_out.short_term_steps = r_res.st_steps;
    assign o_out.block_ready      = r_res.block_ready;
    assign o_out.peak_magnitude   = r_res_peak;
endmodule

FILE: rtl/core/kwl_checker.sv
// ============================================================================
// kwl_checker
// Port-level checks of the loudness window core, bound to the top level.
// ============================================================================
module kwl_checker #(
    parameter int MOMENTARY_STEPS  = 4,
    parameter int SHORT_TERM_STEPS = 30,
    parameter int SAMPLE_BITS      = 24
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [kwl_pkg::SUM_BITS-1:0]     i_momentary_sum,
    input logic [kwl_pkg::MOM_CNT_BITS-1:0] i_momentary_steps,
    input logic [kwl_pkg::SUM_BITS-1:0]     i_short_term_sum,
    input logic                             i_block_ready,
    input logic [SAMPLE_BITS-1:0]           i_peak_magnitude
);
    import kwl_pkg::*;

    // One transaction at a time is in work
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again right after a transaction");

    // Gating flag agrees with the momentary step count
    a_block_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_block_ready ==
                         (i_momentary_steps == MOM_CNT_BITS'(MOMENTARY_STEPS))))
        else $error("block_ready disagrees with momentary step count");

    // The shorter window never exceeds the longer one
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (MOMENTARY_STEPS <= SHORT_TERM_STEPS)
        |-> (i_momentary_sum <= i_short_term_sum))
        else $error("momentary sum above short-term sum");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_momentary_sum)
                                        && $stable(i_peak_magnitude))
        else $error("stalled result changed");
endmodule

bind k_weighted_loudness_windows_core kwl_checker #(
    .MOMENTARY_STEPS  (MOMENTARY_STEPS),
    .SHORT_TERM_STEPS (SHORT_TERM_STEPS),
    .SAMPLE_BITS      (SAMPLE_BITS)
) u_kwl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_momentary_sum   (o_out.momentary_sum),
    .i_momentary_steps (o_out.momentary_steps),
    .i_short_term_sum  (o_out.short_term_sum),
    .i_block_ready     (o_out.block_ready),
    .i_peak_magnitude  (o_out.peak_magnitude)
);
